>>> hdl/iol_pkg.sv
// Package for the indexed ordered list: command and result words, operation
// and status codes, and the per-cell control word of the shifting chain.
// Depends on nothing; every other file imports it.
`default_nettype none

package iol_pkg;

    localparam int DW = 32;  // Width of one stored value.
    localparam int PW = 5;   // Width of the position field.
    localparam int NW = 5;   // Width of the count field.

    // Operation codes carried in the func field.
    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_PREPEND   = 3'd1,
        OP_POP_LAST  = 3'd2,
        OP_POP_FIRST = 3'd3,
        OP_READ      = 3'd4,
        OP_WRITE     = 3'd5,
        OP_INSERT    = 3'd6,
        OP_REMOVE_AT = 3'd7
    } t_func;

    // Status codes returned with every result word.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Input word.
    typedef struct packed {
        t_func                  func;
        logic [PW-1:0]          position;
        logic signed [DW-1:0]   data_in;
    } t_cmd_word;

    // Result word.
    typedef struct packed {
        t_status                status;
        logic signed [DW-1:0]   data_out;
        logic [NW-1:0]          count;
    } t_res_word;

    // Source of a cell's next value.
    typedef enum logic [1:0] {
        SEL_HOLD = 2'd0,
        SEL_LOAD = 2'd1,
        SEL_PREV = 2'd2,
        SEL_NEXT = 2'd3
    } t_cell_sel;

    // Control word handed to each cell.
    typedef struct packed {
        t_cell_sel              sel;
        logic signed [DW-1:0]   data;
    } t_cell_cmd;

endpackage

`default_nettype wire

>>> hdl/indexed_ordered_list.sv
// Indexed ordered list: a chain of CAPACITY cells that shifts as a whole.
// The result word is registered: it appears on o_res with o_done in the cycle after start is accepted.
// Throughput: one word per cycle; busy is tied low.
// Reset (synchronous, active low) empties the list and clears the strobe;
// cell contents are left as they are and are never read before written.
`default_nettype none

module indexed_ordered_list #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  iol_pkg::t_cmd_word  i_cmd,
    output logic                busy,
    output logic                o_done,
    output iol_pkg::t_res_word  o_res
);
    import iol_pkg::*;

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > PW) ? FW : PW;

    logic                 r_done;
    t_res_word            r_res;
    logic [FW-1:0]        r_fill;
    logic [FW-1:0]        n_fill;
    t_res_word            n_res;
    t_status              n_status;

    logic                 accept;
    logic [CW-1:0]        pos_x;
    logic [CW-1:0]        fill_x;
    logic                 is_full;
    logic                 is_empty;
    logic                 do_open;
    logic                 do_close;
    logic                 do_write;
    logic                 do_dec;
    logic [CW-1:0]        tgt;
    logic signed [DW-1:0] rd_value;

    t_cell_cmd            cell_cmd [CAPACITY];
    logic signed [DW-1:0] cell_val [CAPACITY];

    assign accept   = start && !busy;
    assign busy     = 1'b0;
    assign pos_x    = CW'(i_cmd.position);
    assign fill_x   = CW'(r_fill);
    assign is_full  = (fill_x >= CW'(CAPACITY));
    assign is_empty = (r_fill == '0);

    // Decode the operation into status, the kind of chain move and its target.
    always_comb begin
        do_open  = 1'b0;
        do_close = 1'b0;
        do_write = 1'b0;
        do_dec   = 1'b0;
        tgt      = pos_x;
        n_status = ST_OK;
        unique case (i_cmd.func)
            OP_APPEND: begin
                tgt = fill_x;
                if (is_full) n_status = ST_FULL;
                else         do_open = 1'b1;
            end
            OP_PREPEND: begin
                tgt = '0;
                if (is_full) n_status = ST_FULL;
                else         do_open = 1'b1;
            end
            OP_POP_LAST: begin
                if (is_empty) n_status = ST_EMPTY;
                else          do_dec = 1'b1;
            end
            OP_POP_FIRST: begin
                tgt = '0;
                if (is_empty) n_status = ST_EMPTY;
                else          do_close = 1'b1;
            end
            OP_READ: begin
                if (pos_x >= fill_x) n_status = ST_RANGE;
            end
            OP_WRITE: begin
                if (pos_x >= fill_x) n_status = ST_RANGE;
                else                 do_write = 1'b1;
            end
            OP_INSERT: begin
                priority if (pos_x > fill_x) n_status = ST_RANGE;
                else if (is_full)           n_status = ST_FULL;
                else                        do_open = 1'b1;
            end
            OP_REMOVE_AT: begin
                priority if (is_empty)     n_status = ST_EMPTY;
                else if (pos_x >= fill_x)  n_status = ST_RANGE;
                else                       do_close = 1'b1;
            end
            default: n_status = ST_OK;
        endcase
    end

    // Read port: select the addressed cell for a successful read.
    always_comb begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos_x == CW'(i)) rd_value = cell_val[i];
        end
    end

    // Next fill count and the result word.
    always_comb begin
        n_fill = r_fill;
        if (do_open)                n_fill = r_fill + FW'(1);
        else if (do_close || do_dec) n_fill = r_fill - FW'(1);
        n_res.status   = n_status;
        n_res.data_out = (i_cmd.func == OP_READ && n_status == ST_OK) ? rd_value : '0;
        n_res.count    = NW'(n_fill);
    end

    // Per-cell control: open a gap at the target, close it, or overwrite it.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_cmd[i].data = i_cmd.data_in;
            cell_cmd[i].sel  = SEL_HOLD;
            if (accept) begin
                if (do_open) begin
                    if (CW'(i) == tgt)     cell_cmd[i].sel = SEL_LOAD;
                    else if (CW'(i) > tgt) cell_cmd[i].sel = SEL_PREV;
                end else if (do_close) begin
                    if (CW'(i) >= tgt)     cell_cmd[i].sel = SEL_NEXT;
                end else if (do_write) begin
                    if (CW'(i) == tgt)     cell_cmd[i].sel = SEL_LOAD;
                end
            end
        end
    end

    // The chain of cells; the ends see zero in front and themselves behind.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DW-1:0] prev_v;
        logic signed [DW-1:0] next_v;
        if (g == 0) begin : g_first
            assign prev_v = '0;
        end else begin : g_mid_prev
            assign prev_v = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_v = cell_val[g];
        end else begin : g_mid_next
            assign next_v = cell_val[g+1];
        end
        iol_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd[g]),
            .i_prev  (prev_v),
            .i_next  (next_v),
            .o_value (cell_val[g])
        );
    end

    // Control registers: fill count and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) r_fill <= n_fill;
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (accept) r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

>>> hdl/iol_cell.sv
// One storage cell of the list chain: holds one value and, per cycle, keeps
// it, loads new data, or takes the value of its front or back neighbor.
// Depends on iol_pkg.
`default_nettype none

module iol_cell (
    input  logic                            i_clk,
    input  iol_pkg::t_cell_cmd              i_cmd,
    input  logic signed [iol_pkg::DW-1:0]   i_prev,
    input  logic signed [iol_pkg::DW-1:0]   i_next,
    output logic signed [iol_pkg::DW-1:0]   o_value
);
    import iol_pkg::*;

    logic signed [DW-1:0] r_value;
    logic signed [DW-1:0] n_value;

    // Pick the source of the next value.
    always_comb begin
        unique case (i_cmd.sel)
            SEL_HOLD: n_value = r_value;
            SEL_LOAD: n_value = i_cmd.data;
            SEL_PREV: n_value = i_prev;
            SEL_NEXT: n_value = i_next;
            default:  n_value = r_value;
        endcase
    end

    // Payload register; its content is meaningful only below the fill mark.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

>>> hdl/iol_checker.sv
// Port-level checker for the indexed ordered list, bound to the top level.
// Depends on iol_pkg and on the ports of indexed_ordered_list.
`default_nettype none

module iol_checker #(
    parameter int CAPACITY = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input iol_pkg::t_res_word  o_res
);
    import iol_pkg::*;

    // Every accepted word gives exactly one result in the next cycle.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted word gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result word without an accepted word");

    // A failed operation leaves the length unchanged.
    a_fail_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done) && o_res.status != ST_OK)
            |-> (o_res.count == $past(o_res.count)))
        else $error("failed operation changed the length");

    // A failed operation returns zero data.
    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_OK) |-> (o_res.data_out == '0))
        else $error("failed operation returned data");

    // A full report comes only with a full list.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_FULL) |-> (o_res.count == NW'(CAPACITY)))
        else $error("full status with a list that is not full");

endmodule

bind indexed_ordered_list iol_checker #(.CAPACITY(CAPACITY)) u_iol_checker (.*);

`default_nettype wire

>>> tb/sv/iol_list_checker.sv
// Checker for the indexed ordered list: watches the command and result words,
// keeps its own copy of the list, and compares every result word in order.
// Depends on iol_pkg for the word types and the operation and status codes.
`timescale 1ns / 100ps

module iol_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  iol_pkg::t_cmd_word  i_cmd,
    input  logic                i_done,
    input  iol_pkg::t_res_word  i_res,
    output int                  o_errors,
    output int                  o_pending
);
    import iol_pkg::*;

    // Shadow list: entries packed at 0..fill-1, position 0 at the front.
    logic signed [DW-1:0] cells [CAPACITY];
    int unsigned          fill;
    t_res_word            awaited_res [$];
    int                   err_count = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // Shifts everything at and behind the position back by one and stores the value.
    function automatic void open_slot(input int unsigned at, input logic signed [DW-1:0] v);
        for (int i = fill; i > at; i--)
            cells[i] = cells[i-1];
        cells[at] = v;
        fill++;
    endfunction

    // Drops the entry at the position and closes the gap.
    function automatic void close_slot(input int unsigned at);
        for (int i = at; i + 1 < fill; i++)
            cells[i] = cells[i+1];
        fill--;
    endfunction

    // Applies one command word to the shadow list and returns the result word.
    function automatic t_res_word apply_list_op(input t_cmd_word w);
        t_res_word   r;
        int unsigned p;
        r.status   = ST_OK;
        r.data_out = '0;
        p          = w.position;
        case (w.func)
            OP_APPEND: begin
                if (fill >= CAPACITY) r.status = ST_FULL;
                else open_slot(fill, w.data_in);
            end
            OP_PREPEND: begin
                if (fill >= CAPACITY) r.status = ST_FULL;
                else open_slot(0, w.data_in);
            end
            OP_POP_LAST: begin
                if (fill == 0) r.status = ST_EMPTY;
                else fill--;
            end
            OP_POP_FIRST: begin
                if (fill == 0) r.status = ST_EMPTY;
                else close_slot(0);
            end
            OP_READ: begin
                if (p >= fill) r.status = ST_RANGE;
                else r.data_out = cells[p];
            end
            OP_WRITE: begin
                if (p >= fill) r.status = ST_RANGE;
                else cells[p] = w.data_in;
            end
            OP_INSERT: begin
                // The index is checked before fullness.
                if (p > fill) r.status = ST_RANGE;
                else if (fill >= CAPACITY) r.status = ST_FULL;
                else open_slot(p, w.data_in);
            end
            default: begin
                if (fill == 0) r.status = ST_EMPTY;
                else if (p >= fill) r.status = ST_RANGE;
                else close_slot(p);
            end
        endcase
        r.count = fill[NW-1:0];
        return r;
    endfunction

    // Results are compared before the word accepted at the same edge is predicted.
    always @(posedge i_clk) begin
        t_res_word want;
        if (!i_rst_n) begin
            fill = 0;
            awaited_res.delete();
        end else begin
            if (i_done) begin
                if (awaited_res.size() == 0) begin
                    report_mismatch("unexpected result word", 64'(i_res), '0);
                end else begin
                    want = awaited_res.pop_front();
                    if (i_res.status !== want.status)
                        report_mismatch("status", 64'(i_res.status), 64'(want.status));
                    if (i_res.data_out !== want.data_out)
                        report_mismatch("data_out", 64'(i_res.data_out), 64'(want.data_out));
                    if (i_res.count !== want.count)
                        report_mismatch("count", 64'(i_res.count), 64'(want.count));
                end
            end
            if (i_start && !i_busy)
                awaited_res.push_back(apply_list_op(i_cmd));
        end
        o_errors  <= err_count;
        o_pending <= awaited_res.size();
    end

endmodule

>>> tb/sv/tb_indexed_ordered_list.sv
// Top of the indexed ordered list testbench: clock, reset, directed and random
// command words with varying sender gaps, and the final verdict.
// Depends on iol_pkg, the indexed_ordered_list block and iol_list_checker.
`timescale 1ns / 100ps

module tb_indexed_ordered_list;
    import iol_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_WORDS = 1520;
    localparam logic signed [DW-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [DW-1:0] V_MAX = 32'sh7FFF_FFFF;

    typedef enum int { DRIFT_NONE, DRIFT_GROW, DRIFT_SHRINK } t_drift;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_cmd_word   i_cmd   = '0;
    logic        busy;
    logic        o_done;
    t_res_word   o_res;
    int          errors;
    int          pending;
    int unsigned cycles = 0;

    indexed_ordered_list #(.CAPACITY(CAPACITY)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    iol_list_checker #(.CAPACITY(CAPACITY)) u_list_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (i_cmd),
        .i_done    (o_done),
        .i_res     (o_res),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("indexed_ordered_list verification failed");
            $finish;
        end
    end

    // Extremes show up often so that every data bit toggles.
    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Presents one command word and holds it until the block takes it.
    task automatic issue(input t_func f, input int unsigned pos,
                         input logic signed [DW-1:0] v);
        t_cmd_word w;
        w.func     = f;
        w.position = pos[PW-1:0];
        w.data_in  = v;
        start <= 1'b1;
        i_cmd <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // With the given chance in percent, drops start before the next word.
    task automatic idle_gap(input int unsigned pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned idle_pct [3] = '{0, 69, 17};
        t_drift      drift;
        t_func       f;
        int unsigned pos;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every failure on an empty list, then a few edits.
        issue(OP_POP_LAST, 0, '0);
        issue(OP_POP_FIRST, 0, '0);
        issue(OP_REMOVE_AT, 0, '0);
        issue(OP_READ, 0, '0);
        issue(OP_WRITE, 0, V_MAX);
        issue(OP_INSERT, 1, V_MAX);
        issue(OP_INSERT, 0, V_MAX);
        issue(OP_APPEND, 0, V_MIN);
        issue(OP_PREPEND, 0, '1);
        issue(OP_WRITE, 1, '0);
        issue(OP_READ, 2, '0);
        issue(OP_INSERT, 3, 32'sh5A5A_5A5A);
        issue(OP_REMOVE_AT, 4, '0);
        issue(OP_REMOVE_AT, 1, '0);
        issue(OP_READ, 16, '0);

        // Fill up to capacity with inserts at random valid positions.
        for (int n = 3; n < CAPACITY; n++)
            issue(OP_INSERT, $urandom_range(0, n), pick_value());

        // Directed: behavior of a full list.
        issue(OP_APPEND, 0, V_MIN);
        issue(OP_INSERT, 16, V_MAX);
        issue(OP_READ, 15, '0);
        issue(OP_WRITE, 15, V_MIN);
        issue(OP_REMOVE_AT, 16, '0);
        issue(OP_POP_LAST, 0, '0);

        // Random words in phases of sender idling; the drift toward growing or
        // shrinking changes often so that the list visits both full and empty.
        drift = DRIFT_NONE;
        foreach (idle_pct[ph]) begin
            for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
                if (n % 40 == 0)
                    drift = t_drift'($urandom_range(0, 2));
                f = t_func'($urandom_range(0, 7));
                if ($urandom_range(0, 99) < 60) begin
                    if (drift == DRIFT_GROW)
                        case ($urandom_range(0, 2))
                            0:       f = OP_APPEND;
                            1:       f = OP_PREPEND;
                            default: f = OP_INSERT;
                        endcase
                    else if (drift == DRIFT_SHRINK)
                        case ($urandom_range(0, 2))
                            0:       f = OP_POP_LAST;
                            1:       f = OP_POP_FIRST;
                            default: f = OP_REMOVE_AT;
                        endcase
                end
                pos = $urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom_range(0, 3);
                idle_gap(idle_pct[ph]);
                issue(f, pos, pick_value());
            end
        end

        // Drain: wait for every awaited result word before the verdict.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (errors == 0)
            $display("indexed_ordered_list verification clean");
        else
            $display("indexed_ordered_list verification failed");
        $finish;
    end

endmodule
